### rtl/core/u8bc_pkg.sv
// Shared types and byte-class constants for the UTF-8 buffer checker.
`default_nettype none
package u8bc_pkg;

  localparam int unsigned ByteW = 8;

  // Byte values that can never appear in UTF-8
  localparam logic [ByteW-1:0] BYTE_C0      = 8'hC0;
  localparam logic [ByteW-1:0] BYTE_C1      = 8'hC1;
  localparam logic [ByteW-1:0] BYTE_F5      = 8'hF5;

  // Lead and continuation class masks and patterns
  localparam logic [ByteW-1:0] MASK_LEAD2   = 8'hE0;
  localparam logic [ByteW-1:0] PAT_LEAD2    = 8'hC0;
  localparam logic [ByteW-1:0] MASK_LEAD3   = 8'hF0;
  localparam logic [ByteW-1:0] PAT_LEAD3    = 8'hE0;
  localparam logic [ByteW-1:0] MASK_LEAD4   = 8'hF8;
  localparam logic [ByteW-1:0] PAT_LEAD4    = 8'hF0;
  localparam logic [ByteW-1:0] MASK_CONT    = 8'hC0;
  localparam logic [ByteW-1:0] PAT_CONT     = 8'h80;

  localparam logic [1:0]       WIN_FULL     = 2'd3;

  // Verdict handed from the judge stage to the output stage
  typedef struct packed {
    logic push;      // a final byte was transferred this cycle
    logic not_utf8;  // verdict for that buffer
  } verdict_t;

endpackage
`default_nettype wire

### rtl/core/u8bc_judge.sv
// Byte window, lead judging and per-buffer error flags.
`default_nettype none
module u8bc_judge (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    fire,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    last_byte,
  output u8bc_pkg::verdict_t           verdict
);

  logic [7:0] win0_r, win1_r, win2_r;
  logic [1:0] seen_r,  seen_nxt;
  logic [1:0] skip_r,  skip_nxt;
  logic       forb_r,  forb_nxt;
  logic       serr_r,  serr_nxt;
  logic       multi_r, multi_nxt;

  function automatic logic is_cont(input logic [7:0] b);
    is_cont = (b & u8bc_pkg::MASK_CONT) == u8bc_pkg::PAT_CONT;
  endfunction

  always_comb begin
    forb_nxt  = forb_r;
    serr_nxt  = serr_r;
    multi_nxt = multi_r;
    skip_nxt  = skip_r;
    seen_nxt  = (seen_r == u8bc_pkg::WIN_FULL) ? seen_r : seen_r + 2'd1;

    if (data_byte == u8bc_pkg::BYTE_C0 || data_byte == u8bc_pkg::BYTE_C1 ||
        data_byte >= u8bc_pkg::BYTE_F5) begin
      forb_nxt = 1'b1;
    end

    if (seen_r == u8bc_pkg::WIN_FULL) begin
      if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end else if ((win0_r & u8bc_pkg::MASK_LEAD2) == u8bc_pkg::PAT_LEAD2) begin
        if (!is_cont(win1_r)) begin
          serr_nxt = 1'b1;
        end else begin
          multi_nxt = 1'b1;
          skip_nxt  = 2'd1;
        end
      end else if ((win0_r & u8bc_pkg::MASK_LEAD3) == u8bc_pkg::PAT_LEAD3) begin
        if (!is_cont(win1_r) || !is_cont(win2_r)) begin
          serr_nxt = 1'b1;
        end else begin
          multi_nxt = 1'b1;
          skip_nxt  = 2'd2;
        end
      end else if ((win0_r & u8bc_pkg::MASK_LEAD4) == u8bc_pkg::PAT_LEAD4) begin
        if (!is_cont(win1_r) || !is_cont(win2_r) || !is_cont(data_byte)) begin
          serr_nxt = 1'b1;
        end else begin
          multi_nxt = 1'b1;
          skip_nxt  = 2'd3;
        end
      end
    end
  end

  assign verdict = '{push:     fire && last_byte,
                     not_utf8: forb_nxt || serr_nxt || !multi_nxt};

  // Window bytes only matter once seen_r is full, so they need no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      win0_r <= last_byte ? 8'h00 : win1_r;
      win1_r <= last_byte ? 8'h00 : win2_r;
      win2_r <= last_byte ? 8'h00 : data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 2'd0;
      skip_r  <= 2'd0;
      forb_r  <= 1'b0;
      serr_r  <= 1'b0;
      multi_r <= 1'b0;
    end else if (fire) begin
      if (last_byte) begin
        seen_r  <= 2'd0;
        skip_r  <= 2'd0;
        forb_r  <= 1'b0;
        serr_r  <= 1'b0;
        multi_r <= 1'b0;
      end else begin
        seen_r  <= seen_nxt;
        skip_r  <= skip_nxt;
        forb_r  <= forb_nxt;
        serr_r  <= serr_nxt;
        multi_r <= multi_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/u8bc_skid.sv
// Output register plus one skid entry for verdicts.
`default_nettype none
module u8bc_skid (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire u8bc_pkg::verdict_t      verdict,
  output logic                         full,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_not_utf8
);

  logic main_vld_r, skid_vld_r;
  logic main_dat_r, skid_dat_r;
  logic pop;

  assign pop          = main_vld_r && !out_stall;
  assign full         = skid_vld_r;
  assign out_valid    = main_vld_r;
  assign out_not_utf8 = main_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (verdict.push) begin
      if (!main_vld_r || pop) begin
        main_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_dat_r <= skid_dat_r;
      end
    end else if (verdict.push) begin
      if (!main_vld_r || pop) begin
        main_dat_r <= verdict.not_utf8;
      end else begin
        skid_dat_r <= verdict.not_utf8;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/utf8_buffer_check.sv
// Top level of the UTF-8 buffer checker: one verdict per byte stream buffer.
// Throughput: one byte per cycle while in_stall is low; the window moves per byte.
// The verdict is registered, in the output register or, on a stall, the skid entry.
// in_stall rises only when both the output register and the skid entry hold verdicts.
// Reset: synchronous, active low; clears window count, flags and output valids.
`default_nettype none
module utf8_buffer_check (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  // verdict channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_not_utf8
);

  u8bc_pkg::verdict_t verdict;
  logic               in_fire;
  logic               skid_full;

  // A byte transfers whenever the skid entry is free, whether or not a verdict waits.
  assign in_stall = skid_full;
  assign in_fire  = in_valid && !in_stall;

  // Window, skip counter and error flags; the verdict is formed from next-state flags.
  u8bc_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .verdict   (verdict)
  );

  // Output register with one skid entry so a stalled verdict does not block input.
  u8bc_skid u_skid (
    .clk          (clk),
    .rst_n        (rst_n),
    .verdict      (verdict),
    .full         (skid_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_not_utf8 (out_not_utf8)
  );

  // Skid entry is only used behind an occupied output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry full while output register empty");

  // A final-byte transfer always leaves out_valid high on the next cycle.
  a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> out_valid)
    else $error("no verdict after final byte");

  // A verdict still present after a stall plus a new final byte must fill the skid.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && in_valid && !in_stall && in_last_byte) |=> in_stall)
    else $error("verdict lost while output stalled");

endmodule
`default_nettype wire

### tb/utf8_buffer_check_tb.sv
// Self-checking testbench for utf8_buffer_check: directed and random byte buffers.
`timescale 1ns / 1ps
module utf8_buffer_check_tb;

  // Cycles without any transfer on either channel before the run is declared hung.
  // Random stalls and gaps are short, so this is far above any correct run.
  localparam int WatchdogLimit = 4000;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_not_utf8;

  // Idle rates for the current phase, in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int error_count    = 0;
  int quiet_cycles   = 0;

  // Verdicts predicted for buffers whose final byte has been transferred
  logic       verdict_q[$];
  logic       expected_verdict;

  // Bytes of the buffer being sent
  logic [7:0] buf_q[$];

  // Predictor state: three-byte window (0 is oldest), fill count, skip count, flags
  logic [7:0] win[3]        = '{8'h00, 8'h00, 8'h00};
  logic [1:0] win_fill      = 2'd0;
  logic [1:0] skip_left     = 2'd0;
  logic       saw_forbidden = 1'b0;
  logic       saw_bad_seq   = 1'b0;
  logic       saw_multibyte = 1'b0;

  utf8_buffer_check DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_not_utf8 (out_not_utf8)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic is_cont(input logic [7:0] b);
    return (b & u8bc_pkg::MASK_CONT) == u8bc_pkg::PAT_CONT;
  endfunction

  function automatic logic [7:0] rand_cont();
    logic [7:0] low_bits;
    low_bits = 8'($urandom_range(0, 63));
    return u8bc_pkg::PAT_CONT | low_bits;
  endfunction

  // Advance the predicted buffer state by one transferred byte. The lead in the
  // oldest window slot is judged only once the window is full, i.e. when the
  // third byte after it arrives; that arriving byte is the lead's third
  // continuation for four-byte sequences.
  task automatic predict_verdict(input logic [7:0] b, input logic last);
    logic [7:0] lead;
    lead = win[0];
    if (b == u8bc_pkg::BYTE_C0 || b == u8bc_pkg::BYTE_C1 || b >= u8bc_pkg::BYTE_F5)
      saw_forbidden = 1'b1;
    if (win_fill == u8bc_pkg::WIN_FULL) begin
      if (skip_left != 2'd0) begin
        // byte covered by a sequence already accepted
        skip_left = skip_left - 2'd1;
      end else if ((lead & u8bc_pkg::MASK_LEAD2) == u8bc_pkg::PAT_LEAD2) begin
        if (is_cont(win[1])) begin
          saw_multibyte = 1'b1;
          skip_left = 2'd1;
        end else saw_bad_seq = 1'b1;
      end else if ((lead & u8bc_pkg::MASK_LEAD3) == u8bc_pkg::PAT_LEAD3) begin
        if (is_cont(win[1]) && is_cont(win[2])) begin
          saw_multibyte = 1'b1;
          skip_left = 2'd2;
        end else saw_bad_seq = 1'b1;
      end else if ((lead & u8bc_pkg::MASK_LEAD4) == u8bc_pkg::PAT_LEAD4) begin
        if (is_cont(win[1]) && is_cont(win[2]) && is_cont(b)) begin
          saw_multibyte = 1'b1;
          skip_left = 2'd3;
        end else saw_bad_seq = 1'b1;
      end
      // ASCII and stray continuations as lead: nothing to judge
    end
    win[0] = win[1];
    win[1] = win[2];
    win[2] = b;
    if (win_fill != u8bc_pkg::WIN_FULL) win_fill = win_fill + 2'd1;
    if (last) begin
      verdict_q.push_back(saw_forbidden || saw_bad_seq || !saw_multibyte);
      // buffer done: everything back to its reset value
      win           = '{8'h00, 8'h00, 8'h00};
      win_fill      = 2'd0;
      skip_left     = 2'd0;
      saw_forbidden = 1'b0;
      saw_bad_seq   = 1'b0;
      saw_multibyte = 1'b0;
    end
  endtask

  // One byte transfer. Idle cycles are decided before valid rises, so valid never
  // depends on stall. Valid is left high after the transfer; the next call either
  // keeps it high in the same step or drops it for a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    // in_stall read here is its value before this edge: the transfer condition
    while (in_stall) @(posedge clk);
    predict_verdict(b, last);
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Buffers of one to three bytes: no lead is ever judged, so the verdict is 1
  // even for well-formed content. Also the all-zero byte as a one-byte buffer.
  task automatic test_short_buffers();
    buf_q = '{8'h00};
    send_buffer();
    buf_q = '{8'hC3, 8'hA9};
    send_buffer();
    buf_q = '{8'hE2, 8'h82, 8'hAC};
    send_buffer();
  endtask

  // Well-formed two- and four-byte sequences with enough trailing bytes to be
  // judged; the four-byte lead is judged against the arriving byte itself.
  task automatic test_valid_sequences();
    buf_q = '{8'hC3, 8'hA9, 8'h41, 8'h41};
    send_buffer();
    buf_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_buffer();
  endtask

  // Bad continuation after a three-byte lead; then a buffer where the error comes
  // first and a good sequence follows, so judging keeps going but the verdict sticks.
  task automatic test_broken_sequences();
    buf_q = '{8'hE2, 8'h28, 8'hA1, 8'h20};
    send_buffer();
    buf_q = '{8'hC3, 8'h41, 8'hC3, 8'hA9, 8'h7F, 8'h7F};
    send_buffer();
  endtask

  // A valid sequence does not rescue a buffer holding a forbidden value (0xFF here).
  task automatic test_forbidden_bytes();
    buf_q = '{8'hC3, 8'hA9, 8'hFF, 8'h00};
    send_buffer();
  endtask

  // Mostly well-formed UTF-8 chunks with random content, plus broken sequences,
  // stray continuations and raw noise (which reaches C0, C1 and F5..FF).
  task automatic build_random_buffer();
    int         n_chunks;
    int         kind;
    int         n_cont;
    logic [7:0] b;
    buf_q.delete();
    n_chunks = int'($urandom_range(1, 4));
    repeat (n_chunks) begin
      kind = int'($urandom_range(0, 99));
      if (kind < 25) begin
        b = 8'($urandom_range(8'h00, 8'h7F));
        buf_q.push_back(b);
      end else if (kind < 40) begin
        b = 8'($urandom_range(8'hC2, 8'hDF));
        buf_q.push_back(b);
        buf_q.push_back(rand_cont());
      end else if (kind < 55) begin
        b = 8'($urandom_range(8'hE0, 8'hEF));
        buf_q.push_back(b);
        repeat (2) buf_q.push_back(rand_cont());
      end else if (kind < 70) begin
        b = 8'($urandom_range(8'hF0, 8'hF4));
        buf_q.push_back(b);
        repeat (3) buf_q.push_back(rand_cont());
      end else if (kind < 82) begin
        // lead and 0..2 continuations ended by a non-continuation, which may cut it short
        b = 8'($urandom_range(8'hC2, 8'hF4));
        buf_q.push_back(b);
        n_cont = int'($urandom_range(0, 2));
        repeat (n_cont) buf_q.push_back(rand_cont());
        b = 8'($urandom_range(8'h00, 8'h7F));
        buf_q.push_back(b);
      end else if (kind < 90) begin
        buf_q.push_back(rand_cont());
      end else begin
        b = 8'($urandom_range(8'h00, 8'hFF));
        buf_q.push_back(b);
      end
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_bytes);
    int sent;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_bytes) begin
      build_random_buffer();
      sent += buf_q.size();
      send_buffer();
    end
  endtask

  // Receiver back-pressure: one decision per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Verdict checker: every transfer on the result channel is matched against the
  // oldest predicted verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict transfer: expected none, actual not_utf8=%0b",
                 $time, out_not_utf8);
        error_count++;
      end else begin
        expected_verdict = verdict_q.pop_front();
        if (out_not_utf8 !== expected_verdict) begin
          $display("%0t: not_utf8 mismatch: expected %0b, actual %0b",
                   $time, expected_verdict, out_not_utf8);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d verdicts outstanding",
               $time, verdict_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_short_buffers();
    test_valid_sequences();
    test_broken_sequences();
    test_forbidden_bytes();

    // idle phases: none, sender gaps, receiver stalls, both lightly
    test_random_traffic(0, 0, 245);
    test_random_traffic(57, 0, 245);
    test_random_traffic(0, 57, 245);
    test_random_traffic(12, 12, 245);

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // the extra wait catches any stray extra transfer
    repeat (10) @(posedge clk);

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/core/u8bc_pkg.sv
rtl/core/u8bc_judge.sv
rtl/core/u8bc_skid.sv
rtl/core/utf8_buffer_check.sv
tb/utf8_buffer_check_tb.sv
